>>> src/i2c_master_bit_sequencer_macros.svh
// Assertion helpers for the RTL; only i2cm_back includes them.
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define I2CM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_W         = $clog2(BITS_PER_BYTE);
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);
  localparam int STEP_W        = 3;

  // Bus command codes as they arrive on the input channel
  localparam logic [2:0] CMD_START      = 3'd0;
  localparam logic [2:0] CMD_START_ADDR = 3'd1;
  localparam logic [2:0] CMD_STOP       = 3'd2;
  localparam logic [2:0] CMD_WRITE      = 3'd3;
  localparam logic [2:0] CMD_READ_ACK   = 3'd4;
  localparam logic [2:0] CMD_READ_NACK  = 3'd5;

  // Last step index of the fixed start and stop sequences and of the write and read acknowledge slots
  localparam logic [STEP_W-1:0] START_LAST = 3'd5;
  localparam logic [STEP_W-1:0] STOP_LAST  = 3'd6;
  localparam logic [STEP_W-1:0] ACK_LAST   = 3'd2;
  localparam logic [STEP_W-1:0] RACK_LAST  = 3'd3;

  typedef enum logic [2:0] {
    K_START,
    K_START_ADDR,
    K_STOP,
    K_WRITE,
    K_READ_ACK,
    K_READ_NACK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data_byte;
    logic [7:0]  slave_byte;
    logic        slave_ack;
  } cmd_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_STOP,
    ST_WBIT,
    ST_WACK,
    ST_RREL,
    ST_RBIT,
    ST_RACK
  } seq_state_t;

  // One pin action per result
  typedef enum logic [2:0] {
    ACT_SCL0,
    ACT_SCL1,
    ACT_SDA0,
    ACT_SDA1,
    ACT_REL,
    ACT_RETAKE
  } pin_act_t;

  function automatic pin_act_t start_act(input logic [STEP_W-1:0] step);
    pin_act_t a;
    unique case (step)
      3'd0:    a = ACT_SCL0;
      3'd1:    a = ACT_SDA0;
      3'd2:    a = ACT_SCL1;
      3'd3:    a = ACT_SDA1;
      3'd4:    a = ACT_SDA0;
      default: a = ACT_SCL0;
    endcase
    return a;
  endfunction

  function automatic pin_act_t stop_act(input logic [STEP_W-1:0] step);
    pin_act_t a;
    unique case (step)
      3'd0:    a = ACT_SCL0;
      3'd1:    a = ACT_SDA0;
      3'd2:    a = ACT_SCL1;
      3'd3:    a = ACT_SDA0;
      3'd4:    a = ACT_SDA1;
      3'd5:    a = ACT_SCL0;
      default: a = ACT_SDA0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> src/i2cm_front.sv
`default_nettype none
module i2cm_front (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        in_command,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic [7:0]        in_slave_byte,
  input  wire logic              in_slave_ack,
  input  wire logic              q_full,
  output logic                   q_push,
  output i2cm_pkg::cmd_item_t    q_push_item
);

  logic legal;

  always_comb begin
    legal = 1'b1;
    q_push_item.data_byte  = in_data_byte;
    q_push_item.slave_byte = in_slave_byte;
    q_push_item.slave_ack  = in_slave_ack;
    q_push_item.kind       = i2cm_pkg::K_START;
    unique case (in_command)
      i2cm_pkg::CMD_START:      q_push_item.kind = i2cm_pkg::K_START;
      i2cm_pkg::CMD_START_ADDR: q_push_item.kind = i2cm_pkg::K_START_ADDR;
      i2cm_pkg::CMD_STOP:       q_push_item.kind = i2cm_pkg::K_STOP;
      i2cm_pkg::CMD_WRITE:      q_push_item.kind = i2cm_pkg::K_WRITE;
      i2cm_pkg::CMD_READ_ACK:   q_push_item.kind = i2cm_pkg::K_READ_ACK;
      i2cm_pkg::CMD_READ_NACK:  q_push_item.kind = i2cm_pkg::K_READ_NACK;
      // drop unused codes: accepted, nothing queued
      default:                  legal = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && legal;

endmodule
`default_nettype wire

>>> src/i2cm_queue.sv
`default_nettype none
module i2cm_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire i2cm_pkg::cmd_item_t  push_item,
  output logic                      full,
  output logic                      q_valid,
  output i2cm_pkg::cmd_item_t       q_item,
  input  wire logic                 pop
);

  i2cm_pkg::cmd_item_t                 mem_r [i2cm_pkg::QDEPTH];
  logic [i2cm_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [i2cm_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [i2cm_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;
  logic                                do_pop;

  localparam logic [i2cm_pkg::QCNT_W-1:0] CNT_FULL = i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH);
  localparam logic [i2cm_pkg::QPTR_W-1:0] PTR_LAST =
    i2cm_pkg::QPTR_W'(i2cm_pkg::QDEPTH - 1);

  assign full    = (cnt_r == CNT_FULL);
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> src/i2cm_back.sv
`default_nettype none
`include "i2c_master_bit_sequencer_macros.svh"
module i2cm_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire i2cm_pkg::cmd_item_t  q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_scl_level,
  output logic                      out_sda_level,
  output logic                      out_sda_released,
  output logic [7:0]                out_received_byte,
  output logic                      out_ack_received,
  output logic                      out_last_change
);

  localparam logic [i2cm_pkg::BIT_W-1:0] BIT_TOP = i2cm_pkg::BIT_W'(i2cm_pkg::BITS_PER_BYTE - 1);

  i2cm_pkg::seq_state_t           state_r, state_nxt;
  logic [i2cm_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [i2cm_pkg::BIT_W-1:0]     bit_r, bit_nxt;
  i2cm_pkg::cmd_item_t            cmd_r, cmd_nxt;
  i2cm_pkg::pin_act_t             act;
  logic                           last;
  logic                           step;

  // Bus line state kept across commands
  logic scl_r, scl_nxt;
  logic sda_r, sda_nxt;
  logic rel_r, rel_nxt;

  logic       out_valid_r;
  logic       out_scl_r, out_sda_r, out_rel_r, out_ack_r, out_last_r;
  logic [7:0] out_byte_r;
  logic [7:0] byte_nxt;
  logic       ack_nxt;

  assign step = (state_r != i2cm_pkg::ST_IDLE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    cmd_nxt   = cmd_r;
    q_pop     = 1'b0;
    act       = i2cm_pkg::ACT_SCL0;
    last      = 1'b0;
    unique case (state_r)
      i2cm_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_item;
          cnt_nxt = '0;
          bit_nxt = BIT_TOP;
          unique case (q_item.kind)
            i2cm_pkg::K_START,
            i2cm_pkg::K_START_ADDR: state_nxt = i2cm_pkg::ST_START;
            i2cm_pkg::K_STOP:       state_nxt = i2cm_pkg::ST_STOP;
            i2cm_pkg::K_WRITE:      state_nxt = i2cm_pkg::ST_WBIT;
            default:                state_nxt = i2cm_pkg::ST_RREL;
          endcase
        end
      end
      i2cm_pkg::ST_START: begin
        act  = i2cm_pkg::start_act(cnt_r);
        last = (cnt_r == i2cm_pkg::START_LAST) && (cmd_r.kind == i2cm_pkg::K_START);
        if (step) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == i2cm_pkg::START_LAST) begin
            cnt_nxt   = '0;
            state_nxt = last ? i2cm_pkg::ST_IDLE : i2cm_pkg::ST_WBIT;
          end
        end
      end
      i2cm_pkg::ST_STOP: begin
        act  = i2cm_pkg::stop_act(cnt_r);
        last = (cnt_r == i2cm_pkg::STOP_LAST);
        if (step) begin
          cnt_nxt = cnt_r + 1'b1;
          if (last) begin
            state_nxt = i2cm_pkg::ST_IDLE;
          end
        end
      end
      i2cm_pkg::ST_WBIT: begin
        unique case (cnt_r)
          3'd0:    act = cmd_r.data_byte[bit_r] ? i2cm_pkg::ACT_SDA1 : i2cm_pkg::ACT_SDA0;
          3'd1:    act = i2cm_pkg::ACT_SCL1;
          default: act = i2cm_pkg::ACT_SCL0;
        endcase
        if (step) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == 3'd2) begin
            cnt_nxt = '0;
            bit_nxt = bit_r - 1'b1;
            if (bit_r == '0) begin
              state_nxt = i2cm_pkg::ST_WACK;
            end
          end
        end
      end
      i2cm_pkg::ST_WACK: begin
        // release SDA for the slave, clock the acknowledge slot
        unique case (cnt_r)
          3'd0:    act = i2cm_pkg::ACT_REL;
          3'd1:    act = i2cm_pkg::ACT_SCL1;
          default: act = i2cm_pkg::ACT_SCL0;
        endcase
        last = (cnt_r == i2cm_pkg::ACK_LAST);
        if (step) begin
          cnt_nxt = cnt_r + 1'b1;
          if (last) begin
            state_nxt = i2cm_pkg::ST_IDLE;
          end
        end
      end
      i2cm_pkg::ST_RREL: begin
        act = i2cm_pkg::ACT_REL;
        if (step) begin
          cnt_nxt   = '0;
          bit_nxt   = BIT_TOP;
          state_nxt = i2cm_pkg::ST_RBIT;
        end
      end
      i2cm_pkg::ST_RBIT: begin
        act = (cnt_r == '0) ? i2cm_pkg::ACT_SCL1 : i2cm_pkg::ACT_SCL0;
        if (step) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r != '0) begin
            cnt_nxt = '0;
            bit_nxt = bit_r - 1'b1;
            if (bit_r == '0) begin
              state_nxt = i2cm_pkg::ST_RACK;
            end
          end
        end
      end
      i2cm_pkg::ST_RACK: begin
        unique case (cnt_r)
          3'd0:    act = i2cm_pkg::ACT_RETAKE;
          3'd1:    act = (cmd_r.kind == i2cm_pkg::K_READ_NACK) ?
                         i2cm_pkg::ACT_SDA1 : i2cm_pkg::ACT_SDA0;
          3'd2:    act = i2cm_pkg::ACT_SCL1;
          default: act = i2cm_pkg::ACT_SCL0;
        endcase
        last = (cnt_r == i2cm_pkg::RACK_LAST);
        if (step) begin
          cnt_nxt = cnt_r + 1'b1;
          if (last) begin
            state_nxt = i2cm_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = i2cm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    scl_nxt = scl_r;
    sda_nxt = sda_r;
    rel_nxt = rel_r;
    unique case (act)
      i2cm_pkg::ACT_SCL0:   scl_nxt = 1'b0;
      i2cm_pkg::ACT_SCL1:   scl_nxt = 1'b1;
      i2cm_pkg::ACT_SDA0: begin
        rel_nxt = 1'b0;
        sda_nxt = 1'b0;
      end
      i2cm_pkg::ACT_SDA1: begin
        rel_nxt = 1'b0;
        sda_nxt = 1'b1;
      end
      // a released line reads as pulled up
      i2cm_pkg::ACT_REL: begin
        rel_nxt = 1'b1;
        sda_nxt = 1'b1;
      end
      default:              rel_nxt = 1'b0;
    endcase
    byte_nxt = (last && state_r == i2cm_pkg::ST_RACK) ? cmd_r.slave_byte : 8'd0;
    ack_nxt  = last && (state_r == i2cm_pkg::ST_WACK) && !cmd_r.slave_ack;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2cm_pkg::ST_IDLE;
      cnt_r       <= '0;
      bit_r       <= '0;
      scl_r       <= 1'b0;
      sda_r       <= 1'b0;
      rel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      if (step) begin
        scl_r <= scl_nxt;
        sda_r <= sda_nxt;
        rel_r <= rel_nxt;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (step) begin
      out_scl_r  <= scl_nxt;
      out_sda_r  <= rel_nxt | sda_nxt;
      out_rel_r  <= rel_nxt;
      out_byte_r <= byte_nxt;
      out_ack_r  <= ack_nxt;
      out_last_r <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scl_level     = out_scl_r;
  assign out_sda_level     = out_sda_r;
  assign out_sda_released  = out_rel_r;
  assign out_received_byte = out_byte_r;
  assign out_ack_received  = out_ack_r;
  assign out_last_change   = out_last_r;

  `I2CM_ASSERT_IMPL(a_rel_pulled_up, clk, rst_n, rel_r, sda_r, "released SDA not held high")
  `I2CM_ASSERT_NEXT(a_last_to_idle, clk, rst_n, step && last,
                    state_r == i2cm_pkg::ST_IDLE, "sequencer busy after last change")
  `I2CM_ASSERT_IMPL(a_pop_only_idle, clk, rst_n, q_pop,
                    state_r == i2cm_pkg::ST_IDLE, "command taken while busy")
  `I2CM_ASSERT_IMPL(a_ack_on_last, clk, rst_n, out_valid_r && out_ack_r, out_last_r,
                    "acknowledge flagged before last change")

endmodule
`default_nettype wire

>>> src/i2c_master_bit_sequencer.sv
// I2C master bit sequencer.
// Input channel (in_valid / in_stall): one bus command per item, with the byte to
// send and the levels the slave shows on the read clocks and in the ack slot.
// Output channel (out_valid / out_stall): one item per SCL or SDA line change,
// carrying SCL level, SDA drive level and SDA release; out_last_change marks the
// final change of a command, which also carries the read byte or the ack flag.
// A command expands to 6 (start), 7 (stop), 27 (write), 21 (read) or
// 33 (start plus address) results. Within a command the sequencer emits one
// result per cycle unless out_stall holds a pending result; it takes the next
// command from a two-entry queue only once idle again. An accepted command is
// written into the queue, taken by the idle sequencer, and its results are
// registered at the output. Codes 6 and 7 are taken and dropped without results.
// in_stall rises only while the queue is full. When out_stall is high the
// pending result holds and the sequencer waits; the queue keeps taking commands.
// Synchronous reset (rst_n low) empties the queue, drops any pending result and
// returns the bus lines to SCL low, SDA driven low.
`default_nettype none
module i2c_master_bit_sequencer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_command,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [7:0] in_slave_byte,
  input  wire logic       in_slave_ack,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_scl_level,
  output logic            out_sda_level,
  output logic            out_sda_released,
  output logic [7:0]      out_received_byte,
  output logic            out_ack_received,
  output logic            out_last_change
);

  logic                 q_full;
  logic                 q_push;
  i2cm_pkg::cmd_item_t  q_push_item;
  logic                 q_valid;
  i2cm_pkg::cmd_item_t  q_item;
  logic                 q_pop;

  i2cm_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_data_byte  (in_data_byte),
    .in_slave_byte (in_slave_byte),
    .in_slave_ack  (in_slave_ack),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_item   (q_push_item)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (q_pop)
  );

  i2cm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scl_level     (out_scl_level),
    .out_sda_level     (out_sda_level),
    .out_sda_released  (out_sda_released),
    .out_received_byte (out_received_byte),
    .out_ack_received  (out_ack_received),
    .out_last_change   (out_last_change)
  );

endmodule
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
module tb;

  // Codes outside the command set; the block takes them and drops them
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       rel;
    logic [7:0] rx_byte;
    logic       ack;
    logic       last;
  } line_change_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_command = i2cm_pkg::CMD_START;
  logic [7:0] in_data_byte = 8'h00;
  logic [7:0] in_slave_byte = 8'h00;
  logic       in_slave_ack = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_scl_level;
  logic       out_sda_level;
  logic       out_sda_released;
  logic [7:0] out_received_byte;
  logic       out_ack_received;
  logic       out_last_change;

  i2c_master_bit_sequencer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_data_byte      (in_data_byte),
    .in_slave_byte     (in_slave_byte),
    .in_slave_ack      (in_slave_ack),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scl_level     (out_scl_level),
    .out_sda_level     (out_sda_level),
    .out_sda_released  (out_sda_released),
    .out_received_byte (out_received_byte),
    .out_ack_received  (out_ack_received),
    .out_last_change   (out_last_change)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_change_t expected_changes[$];
  int           mismatches = 0;
  int           send_idle_pct = 27;
  int           recv_idle_pct = 57;
  logic         recv_hold = 1'b0;
  int           quiet_cycles = 0;
  event         start_recv_hold;

  // Line state as the master sees it between commands
  logic bus_scl = 1'b0;
  logic bus_sda = 1'b0;
  logic bus_rel = 1'b0;

  function automatic void note_change();
    line_change_t c;
    c = '0;
    c.scl = bus_scl;
    c.sda = bus_rel ? 1'b1 : bus_sda;
    c.rel = bus_rel;
    expected_changes.push_back(c);
  endfunction

  function automatic void pin_scl(input logic v);
    bus_scl = v;
    note_change();
  endfunction

  function automatic void pin_sda(input logic v);
    bus_rel = 1'b0;
    bus_sda = v;
    note_change();
  endfunction

  function automatic void pin_release();
    bus_rel = 1'b1;
    bus_sda = 1'b1;
    note_change();
  endfunction

  function automatic void close_command(input logic [7:0] rx, input logic ack);
    int k;
    k = expected_changes.size() - 1;
    expected_changes[k].rx_byte = rx;
    expected_changes[k].ack     = ack;
    expected_changes[k].last    = 1'b1;
  endfunction

  function automatic void frame_start();
    pin_scl(1'b0);
    pin_sda(1'b0);
    pin_scl(1'b1);
    pin_sda(1'b1);
    pin_sda(1'b0);
    pin_scl(1'b0);
  endfunction

  // Shift a byte out MSB first, then sample the acknowledge slot
  function automatic logic shift_out_byte(input logic [7:0] data, input logic ack_level);
    for (int i = i2cm_pkg::BITS_PER_BYTE - 1; i >= 0; i--) begin
      pin_sda(data[i]);
      pin_scl(1'b1);
      pin_scl(1'b0);
    end
    pin_release();
    pin_scl(1'b1);
    pin_scl(1'b0);
    return ~ack_level;
  endfunction

  function automatic logic [7:0] shift_in_byte(input logic [7:0] slave, input logic nack);
    pin_release();
    for (int i = 0; i < i2cm_pkg::BITS_PER_BYTE; i++) begin
      pin_scl(1'b1);
      pin_scl(1'b0);
    end
    // take SDA back without changing the held level
    bus_rel = 1'b0;
    note_change();
    pin_sda(nack);
    pin_scl(1'b1);
    pin_scl(1'b0);
    return slave;
  endfunction

  function automatic void predict_bus_changes(input logic [2:0] cmd, input logic [7:0] data,
                                              input logic [7:0] slave, input logic ack);
    logic       got_ack;
    logic [7:0] got_byte;
    case (cmd)
      i2cm_pkg::CMD_START: begin
        frame_start();
        close_command(8'h00, 1'b0);
      end
      i2cm_pkg::CMD_START_ADDR: begin
        frame_start();
        got_ack = shift_out_byte(data, ack);
        close_command(8'h00, got_ack);
      end
      i2cm_pkg::CMD_STOP: begin
        pin_scl(1'b0);
        pin_sda(1'b0);
        pin_scl(1'b1);
        pin_sda(1'b0);
        pin_sda(1'b1);
        pin_scl(1'b0);
        pin_sda(1'b0);
        close_command(8'h00, 1'b0);
      end
      i2cm_pkg::CMD_WRITE: begin
        got_ack = shift_out_byte(data, ack);
        close_command(8'h00, got_ack);
      end
      i2cm_pkg::CMD_READ_ACK, i2cm_pkg::CMD_READ_NACK: begin
        got_byte = shift_in_byte(slave, cmd == i2cm_pkg::CMD_READ_NACK);
        close_command(got_byte, 1'b0);
      end
      default: ;
    endcase
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_command(input logic [2:0] cmd, input logic [7:0] data,
                              input logic [7:0] slave, input logic ack);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_data_byte  <= data;
    in_slave_byte <= slave;
    in_slave_ack  <= ack;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_bus_changes(cmd, data, slave, ack);
  endtask

  // Receiver: check each accepted result, then pick the next stall level
  always @(posedge clk) begin
    line_change_t got;
    line_change_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_scl_level, out_sda_level, out_sda_released, out_received_byte,
             out_ack_received, out_last_change};
      if (expected_changes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected line change: scl=%0b sda=%0b rel=%0b ",
                   "rx=%02h ack=%0b last=%0b",
                   got.scl, got.sda, got.rel, got.rx_byte, got.ack, got.last);
      end else begin
        want = expected_changes.pop_front();
        if (got.scl !== want.scl || got.sda !== want.sda || got.rel !== want.rel ||
            got.rx_byte !== want.rx_byte || got.ack !== want.ack ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("line change mismatch: expected scl=%0b sda=%0b rel=%0b ",
                     "rx=%02h ack=%0b last=%0b, ",
                     want.scl, want.sda, want.rel, want.rx_byte, want.ack, want.last,
                     "got scl=%0b sda=%0b rel=%0b rx=%02h ack=%0b last=%0b",
                     got.scl, got.sda, got.rel, got.rx_byte, got.ack, got.last);
        end
      end
    end
    out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
  end

  // Long receiver hold-off, counted here
  initial begin
    forever begin
      @(start_recv_hold);
      @(posedge clk);
      recv_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      recv_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic test_framing();
    send_command(i2cm_pkg::CMD_START, 8'($urandom), 8'($urandom), 1'($urandom));
    send_command(i2cm_pkg::CMD_STOP, 8'($urandom), 8'($urandom), 1'($urandom));
    send_command(i2cm_pkg::CMD_START_ADDR, 8'h00, 8'hFF, 1'b0);
    send_command(i2cm_pkg::CMD_START_ADDR, 8'hFF, 8'h00, 1'b1);
    send_command(CMD_SPARE6, 8'hFF, 8'hFF, 1'b1);
    send_command(i2cm_pkg::CMD_STOP, 8'h00, 8'h00, 1'b0);
    send_command(CMD_SPARE7, 8'h5A, 8'hA5, 1'b0);
    send_command(i2cm_pkg::CMD_START, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_byte_transfers();
    send_command(i2cm_pkg::CMD_WRITE, 8'hFF, 8'h00, 1'b0);
    send_command(i2cm_pkg::CMD_WRITE, 8'h00, 8'hFF, 1'b1);
    send_command(i2cm_pkg::CMD_WRITE, 8'hA5, 8'h00, 1'b0);
    send_command(i2cm_pkg::CMD_READ_ACK, 8'h00, 8'hFF, 1'b1);
    send_command(i2cm_pkg::CMD_READ_ACK, 8'hFF, 8'h00, 1'b0);
    send_command(i2cm_pkg::CMD_READ_NACK, 8'h00, 8'h5A, 1'b0);
    // drive SDA right after a read took the line back for its acknowledge
    send_command(i2cm_pkg::CMD_WRITE, 8'h3C, 8'h00, 1'b1);
    send_command(i2cm_pkg::CMD_READ_NACK, 8'h00, 8'h81, 1'b1);
    send_command(i2cm_pkg::CMD_STOP, 8'h00, 8'h00, 1'b0);
    send_command(i2cm_pkg::CMD_READ_ACK, 8'h00, 8'h7E, 1'b0);
    send_command(i2cm_pkg::CMD_START_ADDR, 8'h5A, 8'h00, 1'b0);
  endtask

  // Mostly whole transactions with random content, some loose commands
  task automatic test_random_traffic(input int n_items);
    int         sent;
    int         n_bytes;
    logic [2:0] code;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        send_command(i2cm_pkg::CMD_START_ADDR, 8'($urandom), 8'($urandom),
                     $urandom_range(99) < 15);
        n_bytes = $urandom_range(3, 1);
        for (int b = 0; b < n_bytes; b++) begin
          if ($urandom_range(1) == 1)
            code = i2cm_pkg::CMD_WRITE;
          else
            code = (b == n_bytes - 1) ? i2cm_pkg::CMD_READ_NACK : i2cm_pkg::CMD_READ_ACK;
          send_command(code, 8'($urandom), 8'($urandom), $urandom_range(99) < 20);
        end
        send_command(i2cm_pkg::CMD_STOP, 8'($urandom), 8'($urandom), 1'($urandom));
        sent += n_bytes + 2;
      end else begin
        code = 3'($urandom_range(7));
        send_command(code, 8'($urandom), 8'($urandom), 1'($urandom));
        if (code <= i2cm_pkg::CMD_READ_NACK) sent++;
      end
    end
  endtask

  // Hold the receiver off while commands keep coming, so the queue fills
  task automatic test_output_backpressure();
    -> start_recv_hold;
    send_command(i2cm_pkg::CMD_START_ADDR, 8'($urandom), 8'($urandom), 1'b0);
    send_command(i2cm_pkg::CMD_WRITE, 8'($urandom), 8'($urandom), 1'($urandom));
    send_command(i2cm_pkg::CMD_READ_ACK, 8'($urandom), 8'($urandom), 1'($urandom));
    send_command(i2cm_pkg::CMD_READ_NACK, 8'($urandom), 8'($urandom), 1'($urandom));
    send_command(i2cm_pkg::CMD_STOP, 8'($urandom), 8'($urandom), 1'($urandom));
    send_command(i2cm_pkg::CMD_START, 8'($urandom), 8'($urandom), 1'($urandom));
    send_command(i2cm_pkg::CMD_STOP, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 27;
    recv_idle_pct = 57;
    test_framing();
    test_byte_transfers();
    test_random_traffic(32);

    send_idle_pct = 57;
    recv_idle_pct = 27;
    test_random_traffic(32);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(32);
    test_output_backpressure();

    in_valid <= 1'b0;
    while (expected_changes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_changes.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
